@@ rtl/assert_macros.svh @@
// assertion macros shared by the bdd evaluator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define BDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define BDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bdd_pkg.sv @@
// shared constants, codes and controller/datapath types for the bdd evaluator
package bdd_pkg;

  localparam int NODES    = 256;
  localparam int NUM_VARS = 64;
  localparam int IDX_W    = $clog2(NODES);
  localparam int CNT_W    = $clog2(NODES + 1);

  localparam logic [1:0] OP_DEFINE = 2'd0;
  localparam logic [1:0] OP_LINK   = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_UNSET = 2'd1;
  localparam logic [1:0] STS_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic is_var;
    logic constant;
    logic [5:0] variable;
  } attr_t;

  typedef struct packed {
    logic def_we;
    logic link_we;
    logic eval_load;
    logic walk;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } sts_t;

endpackage

@@ rtl/bdd_dp.sv @@
// datapath: node store, link stores, walk counter and result registers
`include "assert_macros.svh"

module bdd_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bdd_pkg::cmd_t              cmd,
  output bdd_pkg::sts_t              sts,
  input  logic [7:0]                 in_node_index,
  input  logic                       in_node_is_var,
  input  logic                       in_node_constant,
  input  logic [5:0]                 in_node_variable,
  input  logic                       in_edge_branch,
  input  logic [7:0]                 in_edge_child,
  input  logic [63:0]                in_assignment,
  output logic                       out_value,
  output logic [1:0]                 out_status,
  output logic [8:0]                 out_steps
);

  bdd_pkg::attr_t attr_mem [bdd_pkg::NODES];
  // link words carry their set bit above the child index
  logic [bdd_pkg::IDX_W:0] tlink_mem [bdd_pkg::NODES];
  logic [bdd_pkg::IDX_W:0] flink_mem [bdd_pkg::NODES];

  logic [bdd_pkg::NODES-1:0] node_vld_r;

  bdd_pkg::attr_t attr_rd_r;
  logic [bdd_pkg::IDX_W:0] tlink_rd_r;
  logic [bdd_pkg::IDX_W:0] flink_rd_r;
  logic node_vld_rd_r;

  logic [63:0] assign_r;
  logic [bdd_pkg::CNT_W-1:0] cnt_r;
  logic [bdd_pkg::CNT_W-1:0] cnt_nxt;
  logic value_r;
  logic [1:0] status_r;
  logic [bdd_pkg::CNT_W-1:0] steps_r;

  logic [bdd_pkg::IDX_W-1:0] wr_idx;
  logic [bdd_pkg::IDX_W-1:0] child_idx;
  logic [bdd_pkg::IDX_W-1:0] rd_addr;
  logic def_ok;
  logic link_ok;
  bdd_pkg::attr_t def_attr;

  logic cur_is_var;
  logic at_limit;
  logic branch;
  logic link_set;
  logic [bdd_pkg::IDX_W-1:0] next_node;
  logic done_c;
  logic [bdd_pkg::CNT_W-1:0] cnt_inc;

  // write side
  assign wr_idx    = bdd_pkg::IDX_W'(in_node_index);
  assign child_idx = bdd_pkg::IDX_W'(in_edge_child);
  assign def_ok    = cmd.def_we && (32'(in_node_index) < bdd_pkg::NODES);
  assign link_ok   = cmd.link_we && (32'(in_node_index) < bdd_pkg::NODES)
                     && (32'(in_edge_child) < bdd_pkg::NODES);

  always_comb begin
    def_attr.is_var   = in_node_is_var;
    def_attr.constant = in_node_is_var ? 1'b0 : in_node_constant;
    def_attr.variable = in_node_is_var ? in_node_variable : 6'd0;
  end

  // walk step on the registered node word
  assign cur_is_var = node_vld_rd_r && attr_rd_r.is_var;
  assign at_limit   = (32'(cnt_r) >= bdd_pkg::NODES);
  assign branch     = (32'(attr_rd_r.variable) < bdd_pkg::NUM_VARS)
                      && assign_r[attr_rd_r.variable];
  assign link_set   = branch ? tlink_rd_r[bdd_pkg::IDX_W] : flink_rd_r[bdd_pkg::IDX_W];
  assign next_node  = branch ? tlink_rd_r[bdd_pkg::IDX_W-1:0] : flink_rd_r[bdd_pkg::IDX_W-1:0];
  assign done_c     = !cur_is_var || at_limit || !link_set;
  assign cnt_inc    = cnt_r + 1'b1;
  assign sts.walk_done = done_c;

  // fetch cycle reads the root, walk cycles read the chosen child
  assign rd_addr = cmd.walk ? next_node : '0;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.eval_load) begin
      cnt_nxt = '0;
    end else if (cmd.walk && cur_is_var && !at_limit) begin
      cnt_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (def_ok) begin
      attr_mem[wr_idx] <= def_attr;
    end
    attr_rd_r <= attr_mem[rd_addr];
  end

  // a define clears the link of its node
  always_ff @(posedge clk) begin
    if (def_ok) begin
      tlink_mem[wr_idx] <= '0;
    end else if (link_ok && in_edge_branch) begin
      tlink_mem[wr_idx] <= {1'b1, child_idx};
    end
    tlink_rd_r <= tlink_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (def_ok) begin
      flink_mem[wr_idx] <= '0;
    end else if (link_ok && !in_edge_branch) begin
      flink_mem[wr_idx] <= {1'b1, child_idx};
    end
    flink_rd_r <= flink_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    node_vld_rd_r <= node_vld_r[rd_addr];
    if (cmd.eval_load) begin
      assign_r <= in_assignment;
    end
    if (cmd.walk && done_c) begin
      priority if (!cur_is_var) begin
        value_r  <= node_vld_rd_r && attr_rd_r.constant;
        status_r <= bdd_pkg::STS_OK;
        steps_r  <= cnt_r;
      end else if (at_limit) begin
        value_r  <= 1'b0;
        status_r <= bdd_pkg::STS_LIMIT;
        steps_r  <= cnt_r;
      end else begin
        value_r  <= 1'b0;
        status_r <= bdd_pkg::STS_UNSET;
        steps_r  <= cnt_inc;
      end
    end
  end

  // valid bits: a node never defined reads as terminal 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_vld_r <= '0;
      cnt_r      <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (def_ok) begin
        node_vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  assign out_value  = value_r;
  assign out_status = status_r;
  assign out_steps  = 9'(steps_r);

  `BDD_ASSERT(a_cnt_bound, 32'(cnt_r) <= bdd_pkg::NODES, "walk count beyond node count")

endmodule

@@ rtl/bdd_ctrl.sv @@
// controller: op decode and walk sequencing
`include "assert_macros.svh"

module bdd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_op,
  input  bdd_pkg::sts_t sts,
  output bdd_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  bdd_pkg::state_t st_r;
  bdd_pkg::state_t st_nxt;
  logic eval_acc;
  logic walk_end;

  assign eval_acc = start && !busy && (in_op == bdd_pkg::OP_EVAL);
  assign walk_end = (st_r == bdd_pkg::ST_WALK) && sts.walk_done;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bdd_pkg::ST_IDLE: begin
        if (start && in_op == bdd_pkg::OP_EVAL) begin
          st_nxt = bdd_pkg::ST_FETCH;
        end
      end
      bdd_pkg::ST_FETCH: st_nxt = bdd_pkg::ST_WALK;
      bdd_pkg::ST_WALK: begin
        if (sts.walk_done) begin
          st_nxt = bdd_pkg::ST_DONE;
        end
      end
      bdd_pkg::ST_DONE: st_nxt = bdd_pkg::ST_IDLE;
      default: st_nxt = bdd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (st_r)
      bdd_pkg::ST_IDLE: begin
        // writes complete in the accept cycle itself
        busy          = 1'b0;
        cmd.def_we    = start && (in_op == bdd_pkg::OP_DEFINE);
        cmd.link_we   = start && (in_op == bdd_pkg::OP_LINK);
        cmd.eval_load = start && (in_op == bdd_pkg::OP_EVAL);
      end
      bdd_pkg::ST_FETCH: cmd.walk = 1'b0;
      bdd_pkg::ST_WALK:  cmd.walk = 1'b1;
      bdd_pkg::ST_DONE:  out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bdd_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  `BDD_ASSERT_NEXT(a_eval_busy, eval_acc, busy, "eval word accepted but block not busy")
  `BDD_ASSERT_NEXT(a_done_result, walk_end, out_valid, "finished walk gave no result word")
  `BDD_ASSERT_NEXT(a_single_pulse, out_valid, !out_valid && !busy, "result strobe too long")

endmodule

@@ rtl/bdd_table_evaluator.sv @@
// evaluate: start leads via FETCH (root read) and WALK to DONE, where out_valid
// pulses for a terminal result, an unset link or the step limit; one node of the walk
// per cycle, set by the registered read of the node store. start is taken again after
// the pulse. define and link words complete in the accept cycle and leave busy low.
// rst_n is synchronous active low; it marks every node a terminal 0 with no links.
// the receiver cannot stall: out_valid marks each result word for one cycle only.
module bdd_table_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_node_index,
  input  logic        in_node_is_var,
  input  logic        in_node_constant,
  input  logic [5:0]  in_node_variable,
  input  logic        in_edge_branch,
  input  logic [7:0]  in_edge_child,
  input  logic [63:0] in_assignment,
  output logic        out_valid,
  output logic        out_value,
  output logic [1:0]  out_status,
  output logic [8:0]  out_steps
);

  bdd_pkg::cmd_t cmd;
  bdd_pkg::sts_t sts;

  bdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bdd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_node_index    (in_node_index),
    .in_node_is_var   (in_node_is_var),
    .in_node_constant (in_node_constant),
    .in_node_variable (in_node_variable),
    .in_edge_branch   (in_edge_branch),
    .in_edge_child    (in_edge_child),
    .in_assignment    (in_assignment),
    .out_value        (out_value),
    .out_status       (out_status),
    .out_steps        (out_steps)
  );

endmodule
